// File: rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and codes of the PC hotspot hash counter.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam logic [1:0] OP_NOTE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] STAT_NEW  = 3'd0;
	localparam logic [2:0] STAT_HIT  = 3'd1;
	localparam logic [2:0] STAT_DROP = 3'd2;
	localparam logic [2:0] STAT_OFF  = 3'd3;
	localparam logic [2:0] STAT_NONE = 3'd4;

	// command kinds, decided by the front end
	localparam logic [2:0] K_NOTE  = 3'd0;
	localparam logic [2:0] K_OFF   = 3'd1;
	localparam logic [2:0] K_READ  = 3'd2;
	localparam logic [2:0] K_EMPTY = 3'd3;
	localparam logic [2:0] K_CLEAR = 3'd4;

	localparam logic [31:0] MIX_MUL = 32'h7feb352d;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] pc;
		logic [6:0]  cost;
		logic [31:0] addr;
	} cmd_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] pc;
		logic [63:0] execs;
		logic [63:0] cycles;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        slot_valid;
		logic [31:0] slot_pc;
		logic [63:0] slot_execs;
		logic [63:0] slot_cycles;
		logic [63:0] tot_instr;
		logic [63:0] tot_cycles;
	} res_t;

endpackage

// File: rtl/hsc_fifo.sv
// ----------------------------------------------------------------------------
// hsc_fifo
// Small register queue used between front end, back end and result port.
// ----------------------------------------------------------------------------
module hsc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  buf_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/hsc_front.sv
// ----------------------------------------------------------------------------
// hsc_front
// Takes items, classifies them and hashes the PC into a command.
// ----------------------------------------------------------------------------
module hsc_front #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic [31:0]        exec_pc,
	input  logic signed [7:0]  cost_cycles,
	input  logic [11:0]        slot_index,
	input  logic               enable,
	input  logic               clearing,
	output logic               cmd_push,
	output hsc_pkg::cmd_t      cmd,
	input  logic               cmd_full
);

	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [31:0] pc_s1;
	logic [6:0]  cost_s1;
	logic [11:0] slot_s1;
	logic [31:0] mix_s1;
	logic        accept;
	logic [31:0] prod;
	logic        in_range;

	assign full     = (vld_s1 && cmd_full) || clearing;
	assign accept   = push && !full;
	assign cmd_push = vld_s1 && !cmd_full;
	assign prod     = mix_s1 * hsc_pkg::MIX_MUL;
	assign in_range = {20'b0, slot_s1} < 32'(TABLE_DEPTH);

	always_comb begin
		cmd.pc   = pc_s1;
		cmd.cost = cost_s1;
		cmd.addr = prod ^ (prod >> 15);
		case (op_s1)
			hsc_pkg::OP_NOTE: begin
				cmd.kind = enable ? hsc_pkg::K_NOTE : hsc_pkg::K_OFF;
			end
			hsc_pkg::OP_READ: begin
				cmd.kind = in_range ? hsc_pkg::K_READ : hsc_pkg::K_EMPTY;
				cmd.addr = {20'b0, slot_s1};
			end
			hsc_pkg::OP_CLEAR: begin
				cmd.kind = hsc_pkg::K_CLEAR;
			end
			default: begin
				cmd.kind = hsc_pkg::K_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			pc_s1   <= exec_pc;
			cost_s1 <= (!cost_cycles[7] && cost_cycles != 8'sd0) ? cost_cycles[6:0] : 7'd0;
			slot_s1 <= slot_index;
			mix_s1  <= exec_pc ^ (exec_pc >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (cmd_push) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

// File: rtl/hsc_back.sv
// ----------------------------------------------------------------------------
// hsc_back
// Runs commands against the slot table: probe, update, insert, read, clear.
// ----------------------------------------------------------------------------
module hsc_back #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hsc_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output hsc_pkg::res_t res,
	output logic          clearing
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W:0] OCC_LIMIT = (IDX_W+1)'((7 * TABLE_DEPTH - 1) / 10);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_LOOK  = 2'd2;

	hsc_pkg::entry_t table_q [TABLE_DEPTH];
	hsc_pkg::entry_t rdata_q;
	hsc_pkg::entry_t wdata;
	hsc_pkg::cmd_t   cur_q;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [IDX_W-1:0] addr_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             we;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W:0]   occ_q;
	logic [63:0]      tot_i_q;
	logic [63:0]      tot_c_q;
	logic [63:0]      tot_i_nx;
	logic [63:0]      tot_c_nx;
	logic             load;
	logic             tot_upd;
	logic             tot_clr;
	logic             occ_inc;
	logic             step;
	logic [63:0]      cost64;

	assign clearing = (state_q == S_CLEAR);
	assign cost64   = {57'b0, cur_q.cost};
	assign tot_i_nx = tot_i_q + 64'd1;
	assign tot_c_nx = tot_c_q + cost64;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		res.status     = hsc_pkg::STAT_NONE;
		res.tot_instr  = tot_i_q;
		res.tot_cycles = tot_c_q;
		rd_addr  = addr_q;
		wr_addr  = addr_q;
		wdata    = '0;
		we       = 1'b0;
		load     = 1'b0;
		tot_upd  = 1'b0;
		tot_clr  = 1'b0;
		occ_inc  = 1'b0;
		step     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_q;
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						hsc_pkg::K_NOTE, hsc_pkg::K_READ: begin
							load    = 1'b1;
							rd_addr = cmd.addr[IDX_W-1:0];
							state_d = S_LOOK;
						end
						hsc_pkg::K_OFF: begin
							res_push   = 1'b1;
							res.status = hsc_pkg::STAT_OFF;
						end
						hsc_pkg::K_CLEAR: begin
							res_push       = 1'b1;
							res.tot_instr  = '0;
							res.tot_cycles = '0;
							tot_clr        = 1'b1;
							state_d        = S_CLEAR;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			S_LOOK: begin
				if (cur_q.kind == hsc_pkg::K_READ) begin
					res_push = 1'b1;
					if (rdata_q.valid) begin
						res.slot_valid  = 1'b1;
						res.slot_pc     = rdata_q.pc;
						res.slot_execs  = rdata_q.execs;
						res.slot_cycles = rdata_q.cycles;
					end
					state_d = S_IDLE;
				end else if (rdata_q.valid && rdata_q.pc != cur_q.pc) begin
					step    = 1'b1;
					rd_addr = addr_q + 1'b1;
				end else begin
					res_push       = 1'b1;
					tot_upd        = 1'b1;
					res.tot_instr  = tot_i_nx;
					res.tot_cycles = tot_c_nx;
					state_d        = S_IDLE;
					wdata.valid    = 1'b1;
					wdata.pc       = cur_q.pc;
					if (rdata_q.valid) begin
						we           = 1'b1;
						wdata.execs  = rdata_q.execs + 64'd1;
						wdata.cycles = rdata_q.cycles + cost64;
						res.status   = hsc_pkg::STAT_HIT;
					end else if (occ_q < OCC_LIMIT) begin
						we           = 1'b1;
						occ_inc      = 1'b1;
						wdata.execs  = 64'd1;
						wdata.cycles = cost64;
						res.status   = hsc_pkg::STAT_NEW;
					end else begin
						res.status = hsc_pkg::STAT_DROP;
					end
					if (we) begin
						res.slot_valid  = 1'b1;
						res.slot_pc     = wdata.pc;
						res.slot_execs  = wdata.execs;
						res.slot_cycles = wdata.cycles;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_q[wr_addr] <= wdata;
		end
		rdata_q <= table_q[rd_addr];
		if (load) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			addr_q  <= '0;
			occ_q   <= '0;
			tot_i_q <= '0;
			tot_c_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load || step) begin
				addr_q <= rd_addr;
			end
			if (tot_clr) begin
				occ_q   <= '0;
				tot_i_q <= '0;
				tot_c_q <= '0;
				clr_q   <= '0;
			end else begin
				if (occ_inc) begin
					occ_q <= occ_q + 1'b1;
				end
				if (tot_upd) begin
					tot_i_q <= tot_i_nx;
					tot_c_q <= tot_c_nx;
				end
			end
		end
	end

endmodule

// File: rtl/pc_hotspot_hash_counter_unit.sv
// ----------------------------------------------------------------------------
// pc_hotspot_hash_counter_unit
// Execution profiler: PC-keyed counting in a linearly probed hash table.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | push / full             | opcode exec_pc cost_cycles slot_index
//  result   | pop / empty             | note_status slot_* total_*
//  config   | cfg_valid / cfg_ready   | cfg_data (profile enable)
//
//  A note reads a slot on leaving idle and one more per extra probe step (one
//  table read per cycle); a read also passes the look state, other items are
//  answered from idle. The front end registers each item. After reset and
//  after each clear item a clearing pass over every slot runs with full high.
//  Queues on both sides of the back end let the two sides stall independently.
// ----------------------------------------------------------------------------
module pc_hotspot_hash_counter_unit #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        opcode,
	input  logic [31:0]       exec_pc,
	input  logic signed [7:0] cost_cycles,
	input  logic [11:0]       slot_index,
	output logic              empty,
	input  logic              pop,
	output logic [2:0]        note_status,
	output logic              slot_valid,
	output logic [31:0]       slot_pc,
	output logic [63:0]       slot_executions,
	output logic [63:0]       slot_cycles,
	output logic [63:0]       total_instructions,
	output logic [63:0]       total_cycles,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);

	logic          enable_q;
	logic          clearing;
	logic          cmd_push;
	logic          cmd_full;
	logic          cmd_empty;
	logic          cmd_pop;
	logic          res_push;
	logic          res_full;
	hsc_pkg::cmd_t cmd_in;
	hsc_pkg::cmd_t cmd_out;
	hsc_pkg::res_t res_in;
	hsc_pkg::res_t res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	hsc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.exec_pc     (exec_pc),
		.cost_cycles (cost_cycles),
		.slot_index  (slot_index),
		.enable      (enable_q),
		.clearing    (clearing),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in),
		.cmd_full    (cmd_full)
	);

	hsc_fifo #(.W($bits(hsc_pkg::cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	hsc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.clearing  (clearing)
	);

	hsc_fifo #(.W($bits(hsc_pkg::res_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign note_status        = res_out.status;
	assign slot_valid         = res_out.slot_valid;
	assign slot_pc            = res_out.slot_pc;
	assign slot_executions    = res_out.slot_execs;
	assign slot_cycles        = res_out.slot_cycles;
	assign total_instructions = res_out.tot_instr;
	assign total_cycles       = res_out.tot_cycles;

endmodule
